// File: rtl/limit_switch_actuator_cycler_defines.svh
// Assertion macros for the actuator cycler.
// Both expect signals named clk and rst in the asserting scope.
`ifndef LIMIT_SWITCH_ACTUATOR_CYCLER_DEFINES_SVH
`define LIMIT_SWITCH_ACTUATOR_CYCLER_DEFINES_SVH

// Antecedent implies consequent in the same cycle; the consequent may carry a delay.
`define LSAC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition never holds outside reset.
`define LSAC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// File: rtl/lsac_pkg.sv
package lsac_pkg;

  // Channel count and field widths
  localparam int NUM_CHANNELS = 5;
  localparam int CH_W         = 3;
  localparam int CFG_W        = 22;
  localparam int CFG_IDX_W    = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUALIFY_TICKS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_TIMEOUT_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_TICKS          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_CLEAR_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STROKES_PER_TRIGGER = 3'd5;

  // Register reset values
  localparam logic [15:0] QUALIFY_TICKS_RST       = 16'd100;
  localparam logic [15:0] RUN_TIMEOUT_TICKS_RST   = 16'd30000;
  localparam logic [15:0] REST_TICKS_RST          = 16'd15000;
  localparam logic [7:0]  RETRY_LIMIT_RST         = 8'd3;
  localparam logic [21:0] LOCKOUT_CLEAR_TICKS_RST = 22'd3600000;
  localparam logic [7:0]  STROKES_PER_TRIGGER_RST = 8'd2;

  // Flag and pin bit positions
  localparam int FLG_SW_UP  = 0;
  localparam int FLG_SW_DN  = 1;
  localparam int FLG_DIR_UP = 2;
  localparam int FLG_DIR_DN = 3;
  localparam int PIN_UP     = 0;
  localparam int PIN_DN     = 1;
  localparam int PIN_TRIG   = 2;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            upper_switch_raw;
    logic            lower_switch_raw;
    logic            up_pin_readback;
    logic            down_pin_readback;
  } tick_word_t;

  typedef struct packed {
    logic [CH_W-1:0] channel_out;
    logic            drive_up;
    logic            drive_down;
    logic            trigger_level;
    logic            motion_enabled;
    logic            locked_out;
  } result_word_t;

  // One channel's record in the state memory
  typedef struct packed {
    logic [15:0] switch_qualify_count;
    logic [15:0] direction_qualify_count;
    logic [3:0]  qualified_flags;
    logic        in_motion;
    logic        wanted_direction;
    logic [16:0] run_timer;
    logic [15:0] rest_timer;
    logic [7:0]  retry_count;
    logic [21:0] lockout_timer;
    logic [7:0]  stroke_count;
    logic [2:0]  pin_levels;
  } chan_state_t;

  typedef struct packed {
    logic [15:0] cnt;
    logic        flag;
  } qual_t;

endpackage

// File: rtl/limit_switch_actuator_cycler.sv
// Limit-switch actuator cycler. Each word on tick_word is one millisecond tick
// for one actuator channel; it is taken at a clock edge where start is high and
// busy is low, and a new tick may follow in every cycle. Exactly one result
// word comes back per tick, in order, with done high for one cycle once the
// tick passes the s1 stage and output registers; the receiver cannot stall it. Per-channel
// state lives in one synchronous memory: the tick reads its channel's record
// in the accept cycle and writes the updated record back in the next, and a
// tick for the channel updated in the cycle before takes the record from the
// write-back path instead of the memory. Ticks for channels beyond the last one
// change nothing and return zero drive levels. busy is high only in the cycle
// after reset, while the per-channel valid bits come up cleared. Configuration
// writes take effect at once and are to be made while no tick is in flight.
`include "limit_switch_actuator_cycler_defines.svh"

module limit_switch_actuator_cycler
  import lsac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tick_word_t           tick_word,
  output logic                 done,
  output result_word_t         result_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [CH_W:0] NUM_CH_EXT = (CH_W + 1)'(NUM_CHANNELS);

  // Configuration registers
  logic [15:0] qualify_ticks;
  logic [15:0] run_timeout_ticks;
  logic [15:0] rest_ticks;
  logic [7:0]  retry_limit;
  logic [21:0] lockout_clear_ticks;
  logic [7:0]  strokes_per_trigger;

  // State memory and its valid bits
  chan_state_t             mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  chan_state_t             rd_data;

  // Update stage
  logic        accept;
  logic        in_range;
  logic        s1_valid;
  tick_word_t  s1_word;
  logic        s1_in_range;
  logic        s1_hit;
  logic        s1_rvalid;
  chan_state_t s1_fwd;
  chan_state_t cur;
  chan_state_t st_next;
  logic        wr_en;
  result_word_t res_next;

  function automatic qual_t qual_step(input logic [15:0] cnt, input logic flag,
                                      input logic lvl, input logic [15:0] qt);
    qual_t r;
    r.cnt  = cnt;
    r.flag = flag;
    if (lvl) begin
      r.cnt = cnt + 16'd1;
      if (r.cnt >= qt || r.cnt == 16'd0) begin
        r.cnt  = 16'd0;
        r.flag = 1'b1;
      end
    end else begin
      r.flag = 1'b0;
    end
    return r;
  endfunction

  assign accept   = start && !busy;
  assign in_range = {1'b0, tick_word.channel} < NUM_CH_EXT;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      qualify_ticks       <= QUALIFY_TICKS_RST;
      run_timeout_ticks   <= RUN_TIMEOUT_TICKS_RST;
      rest_ticks          <= REST_TICKS_RST;
      retry_limit         <= RETRY_LIMIT_RST;
      lockout_clear_ticks <= LOCKOUT_CLEAR_TICKS_RST;
      strokes_per_trigger <= STROKES_PER_TRIGGER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUALIFY_TICKS:       qualify_ticks       <= cfg_data[15:0];
        REG_RUN_TIMEOUT_TICKS:   run_timeout_ticks   <= cfg_data[15:0];
        REG_REST_TICKS:          rest_ticks          <= cfg_data[15:0];
        REG_RETRY_LIMIT:         retry_limit         <= cfg_data[7:0];
        REG_LOCKOUT_CLEAR_TICKS: lockout_clear_ticks <= cfg_data[21:0];
        REG_STROKES_PER_TRIGGER: strokes_per_trigger <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Memory: write back the updated record, read the next tick's record
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_word.channel] <= st_next;
    end
    if (accept && in_range) begin
      rd_data <= mem[tick_word.channel];
    end
  end

  // Control: valid bits, stage valid, forwarding select, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      vld       <= '0;
      s1_valid  <= 1'b0;
      s1_hit    <= 1'b0;
      s1_rvalid <= 1'b0;
      done      <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s1_valid <= accept;
      done     <= s1_valid;
      if (wr_en) begin
        vld[s1_word.channel] <= 1'b1;
      end
      if (accept) begin
        s1_hit    <= wr_en && (s1_word.channel == tick_word.channel);
        s1_rvalid <= in_range && vld[tick_word.channel];
      end
    end
  end

  // Payload of the update stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word     <= tick_word;
      s1_in_range <= in_range;
      s1_fwd      <= st_next;
    end
    result_word <= res_next;
  end

  assign wr_en = s1_valid && s1_in_range;

  // Update one channel's record for this tick
  always_comb begin
    qual_t       q;
    logic        sup;
    logic        sdn;
    logic        dup;
    logic        ddn;
    logic        motion;
    logic [16:0] run_inc;

    cur     = s1_hit ? s1_fwd : (s1_rvalid ? rd_data : '0);
    st_next = cur;

    // Qualify switches on their shared counter, upper first
    q = qual_step(cur.switch_qualify_count, cur.qualified_flags[FLG_SW_UP],
                  s1_word.upper_switch_raw, qualify_ticks);
    st_next.qualified_flags[FLG_SW_UP] = q.flag;
    q = qual_step(q.cnt, cur.qualified_flags[FLG_SW_DN],
                  s1_word.lower_switch_raw, qualify_ticks);
    st_next.qualified_flags[FLG_SW_DN] = q.flag;
    st_next.switch_qualify_count = q.cnt;

    // Qualify direction readbacks, up first
    q = qual_step(cur.direction_qualify_count, cur.qualified_flags[FLG_DIR_UP],
                  s1_word.up_pin_readback, qualify_ticks);
    st_next.qualified_flags[FLG_DIR_UP] = q.flag;
    q = qual_step(q.cnt, cur.qualified_flags[FLG_DIR_DN],
                  s1_word.down_pin_readback, qualify_ticks);
    st_next.qualified_flags[FLG_DIR_DN] = q.flag;
    st_next.direction_qualify_count = q.cnt;

    sup = st_next.qualified_flags[FLG_SW_UP];
    sdn = st_next.qualified_flags[FLG_SW_DN];
    dup = st_next.qualified_flags[FLG_DIR_UP];
    ddn = st_next.qualified_flags[FLG_DIR_DN];

    motion  = cur.in_motion;
    run_inc = '0;

    // Stop at the limit in the direction of travel
    if (motion && ((dup && !ddn && sup) || (ddn && !dup && sdn))) begin
      st_next.rest_timer   = rest_ticks;
      st_next.run_timer    = '0;
      motion               = 1'b0;
      st_next.stroke_count = st_next.stroke_count + 8'd1;
    end

    // Abort on run timeout, reverse and count a retry
    if (motion && (dup || ddn)) begin
      run_inc           = st_next.run_timer + 17'd1;
      st_next.run_timer = run_inc;
      if (run_inc > {1'b0, run_timeout_ticks}) begin
        motion               = 1'b0;
        st_next.rest_timer   = rest_ticks;
        st_next.run_timer    = '0;
        st_next.stroke_count = '0;
        if (st_next.retry_count != 8'hFF) begin
          st_next.retry_count = st_next.retry_count + 8'd1;
        end
        if (dup && !ddn) begin
          st_next.wanted_direction = 1'b1;
        end
        if (ddn && !dup) begin
          st_next.wanted_direction = 1'b0;
        end
      end
    end

    // Rest or lockout while stopped
    if (!motion) begin
      st_next.pin_levels[PIN_UP] = 1'b0;
      st_next.pin_levels[PIN_DN] = 1'b0;
      st_next.run_timer          = '0;
      if (st_next.retry_count <= retry_limit) begin
        if (st_next.rest_timer != 16'd0) begin
          st_next.rest_timer = st_next.rest_timer - 16'd1;
          if (sdn) begin
            st_next.wanted_direction = 1'b0;
          end else if (sup) begin
            st_next.wanted_direction = 1'b1;
          end
        end
        if (st_next.rest_timer <= 16'd1) begin
          motion = 1'b1;
        end
      end else begin
        st_next.lockout_timer = st_next.lockout_timer + 22'd1;
        if (st_next.lockout_timer >= lockout_clear_ticks) begin
          st_next.retry_count   = '0;
          st_next.lockout_timer = '0;
        end
      end
    end

    // Drive the pins for a move
    if (motion) begin
      if (st_next.wanted_direction && !ddn) begin
        if (st_next.stroke_count == strokes_per_trigger) begin
          st_next.pin_levels[PIN_TRIG] = 1'b1;
          st_next.retry_count          = '0;
        end
        st_next.pin_levels[PIN_DN] = 1'b1;
        st_next.run_timer          = '0;
        st_next.stroke_count       = '0;
      end else if (!st_next.wanted_direction && !dup) begin
        st_next.pin_levels[PIN_TRIG] = 1'b0;
        st_next.pin_levels[PIN_UP]   = 1'b1;
        st_next.run_timer            = '0;
      end
    end

    st_next.in_motion = motion;

    // Form the result word
    res_next.channel_out = s1_word.channel;
    if (s1_in_range) begin
      res_next.drive_up       = st_next.pin_levels[PIN_UP];
      res_next.drive_down     = st_next.pin_levels[PIN_DN];
      res_next.trigger_level  = st_next.pin_levels[PIN_TRIG];
      res_next.motion_enabled = motion;
      res_next.locked_out     = st_next.retry_count > retry_limit;
    end else begin
      res_next.drive_up       = 1'b0;
      res_next.drive_down     = 1'b0;
      res_next.trigger_level  = 1'b0;
      res_next.motion_enabled = 1'b0;
      res_next.locked_out     = 1'b0;
    end
  end

  // Every taken tick returns its word, with done, after the s1 stage and output registers
  `LSAC_ASSERT_IMPLIES(a_tick_returns, start && !busy, ##2 done, "tick without result word")
  // Both direction pins are never driven at once
  `LSAC_ASSERT_NEVER(a_one_direction, done && result_word.drive_up && result_word.drive_down, "both direction pins driven")
  // A tick for a missing channel returns all drive levels low
  `LSAC_ASSERT_IMPLIES(a_missing_channel_quiet, done && ({1'b0, result_word.channel_out} >= NUM_CH_EXT), !result_word.drive_up && !result_word.drive_down && !result_word.trigger_level && !result_word.motion_enabled && !result_word.locked_out, "missing channel returned levels")

endmodule
